// ===== src/alts_pkg.sv =====
// Shared types and constants for the LRU tag store.
package alts_pkg;

  // Fixed field widths of the request and result channels.
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 64;
  localparam int SLOT_W = 4;

  // Command codes carried on the request channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  // Write controls from the sequencer to the entry store.
  typedef struct packed {
    logic wr_en;  // write the recency rank of one entry
    logic fill;   // also write the key and set the valid bit
  } store_ctl_t;

endpackage

// ===== src/alts_if.sv =====
// Request and result channel interfaces of the LRU tag store.
interface alts_req_if;
  import alts_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output cmd, output key, output slot, input ready);
  modport sink (input valid, input cmd, input key, input slot, output ready);
endinterface

interface alts_rsp_if;
  import alts_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] slot_out;
  logic              replaced;

  modport source (output valid, output found, output slot_out, output replaced, input ready);
  modport sink (input valid, input found, input slot_out, input replaced, output ready);
endinterface

// ===== src/alts_store.sv =====
// Entry store: key and recency memories with valid and rank-written flags.
module alts_store
  import alts_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64,
  localparam int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IDX_W-1:0]    rd_addr,
  input  store_ctl_t          ctl,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic [IDX_W-1:0]    wr_rank,
  output logic [KEY_BITS-1:0] rd_key,
  output logic [IDX_W-1:0]    rd_rank,
  output logic                rd_valid
);

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [IDX_W-1:0]    rank_mem [ENTRIES];
  logic [IDX_W-1:0]    rank_q;
  logic [IDX_W-1:0]    rd_addr_q;
  logic [ENTRIES-1:0]  valid_bits;
  logic [ENTRIES-1:0]  rank_written;

  // Key memory: one write port, registered read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.fill) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  // Rank memory: one write port, registered read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      rank_mem[wr_addr] <= wr_rank;
    end
    rank_q    <= rank_mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Per-entry flags; an entry whose rank was never written has rank equal to its index.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits   <= '0;
      rank_written <= '0;
    end else if (ctl.wr_en) begin
      rank_written[wr_addr] <= 1'b1;
      if (ctl.fill) begin
        valid_bits[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_rank  = rank_written[rd_addr_q] ? rank_q : rd_addr_q;
  assign rd_valid = valid_bits[rd_addr_q];

endmodule

// ===== src/alts_ctrl.sv =====
// Command sequencer: scan pass, rank update pass and result register.
module alts_ctrl
  import alts_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64,
  localparam int IDX_W   = $clog2(ENTRIES),
  localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  alts_req_if.sink            req,
  alts_rsp_if.source          rsp,
  output logic [IDX_W-1:0]    rd_addr,
  output store_ctl_t          st_ctl,
  output logic [IDX_W-1:0]    wr_addr,
  output logic [KEY_BITS-1:0] wr_key,
  output logic [IDX_W-1:0]    wr_rank,
  input  logic [KEY_BITS-1:0] rd_key,
  input  logic [IDX_W-1:0]    rd_rank,
  input  logic                rd_valid
);

  localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t              state;
  cmd_t                cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [CNT_W-1:0]    cnt;
  logic                pend;
  logic [IDX_W-1:0]    idx_d;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx;
  logic                free_r;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    free_rank;
  logic [IDX_W-1:0]    lru_idx;
  logic [IDX_W-1:0]    lru_rank;
  logic [IDX_W-1:0]    tgt;
  logic [IDX_W-1:0]    old_rank;
  logic                repl_r;
  logic                out_valid;
  logic                out_found;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_repl;

  logic                issue;
  logic                pass_done;
  logic [8:0]          slot_ext;
  logic                slot_in_range;
  logic [IDX_W-1:0]    upd_rank;

  // Read issue: one entry per cycle, its data comes back in the next cycle.
  assign issue     = (cnt < CNT_W'(ENTRIES));
  assign rd_addr   = cnt[IDX_W-1:0];
  assign pass_done = !issue && !pend;

  // Touch of a slot beyond the table leaves the ranks alone.
  assign slot_ext      = 9'(slot_r);
  assign slot_in_range = (slot_ext < 9'(ENTRIES));

  // New rank: the target becomes most recent, ranks above its old rank move down.
  always_comb begin
    if (idx_d == tgt) begin
      upd_rank = RANK_TOP;
    end else if (rd_rank > old_rank) begin
      upd_rank = rd_rank - 1'b1;
    end else begin
      upd_rank = rd_rank;
    end
  end

  assign st_ctl.wr_en = (state == ST_UPDATE) && pend;
  assign st_ctl.fill  = (state == ST_UPDATE) && pend && (cmd_r == CMD_INSERT) && (idx_d == tgt);
  assign wr_addr      = idx_d;
  assign wr_key       = key_r;
  assign wr_rank      = upd_rank;

  assign req.ready    = (state == ST_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.found    = out_found;
  assign rsp.slot_out = out_slot;
  assign rsp.replaced = out_repl;

  // Payload and scan bookkeeping.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd_r  <= cmd_t'(req.cmd);
        key_r  <= req.key[KEY_BITS-1:0];
        slot_r <= req.slot;
        tgt    <= IDX_W'(req.slot);
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end
      ST_SCAN: begin
        if (pend) begin
          // Lookup keeps the lowest matching valid entry.
          if (cmd_r == CMD_LOOKUP && !hit_r && rd_valid && rd_key == key_r) begin
            hit_r   <= 1'b1;
            hit_idx <= idx_d;
          end
          // Touch picks up the old rank of its slot.
          if (cmd_r == CMD_TOUCH && idx_d == tgt) begin
            old_rank <= rd_rank;
          end
          // Insert tracks the lowest free entry and the least recent one.
          if (cmd_r == CMD_INSERT) begin
            if (!rd_valid && !free_r) begin
              free_r    <= 1'b1;
              free_idx  <= idx_d;
              free_rank <= rd_rank;
            end
            if (idx_d == '0 || rd_rank < lru_rank) begin
              lru_idx  <= idx_d;
              lru_rank <= rd_rank;
            end
          end
        end
        if (pass_done && cmd_r == CMD_INSERT) begin
          tgt      <= free_r ? free_idx : lru_idx;
          old_rank <= free_r ? free_rank : lru_rank;
          repl_r   <= !free_r;
        end
      end
      ST_UPDATE: begin
      end
      ST_DONE: begin
        // The result register loads only once a held result has been taken.
        if (!out_valid || rsp.ready) begin
          unique case (cmd_r)
            CMD_LOOKUP: begin
              out_found <= hit_r;
              out_slot  <= hit_r ? SLOT_W'(hit_idx) : '0;
              out_repl  <= 1'b0;
            end
            CMD_TOUCH: begin
              out_found <= 1'b0;
              out_slot  <= slot_r;
              out_repl  <= 1'b0;
            end
            CMD_INSERT: begin
              out_found <= 1'b0;
              out_slot  <= SLOT_W'(tgt);
              out_repl  <= repl_r;
            end
            CMD_RSVD: begin
              out_found <= 1'b0;
              out_slot  <= '0;
              out_repl  <= 1'b0;
            end
            default: begin
              out_found <= 1'b0;
              out_slot  <= '0;
              out_repl  <= 1'b0;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    idx_d <= rd_addr;
  end

  // Control state machine and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt  <= '0;
          pend <= 1'b0;
          if (req.valid) begin
            state <= (cmd_t'(req.cmd) == CMD_RSVD) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend <= issue;
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (pass_done) begin
            cnt <= '0;
            if (cmd_r == CMD_INSERT || (cmd_r == CMD_TOUCH && slot_in_range)) begin
              state <= ST_UPDATE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_UPDATE: begin
          pend <= issue;
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (pass_done) begin
            cnt   <= '0;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/assoc_lru_tag_store.sv =====
// Top level of the fully associative tag store with LRU replacement.
//
//   Channel  Role    Handshake      Payload
//   req      sink    valid / ready  cmd[1:0], key[63:0], slot[3:0]
//   rsp      source  valid / ready  found, slot_out[3:0], replaced
//
// One request is handled at a time. A lookup runs one scan pass over the entries;
// a touch or insert runs a scan pass and then a rank update pass (a touch of a
// slot beyond the table only the scan pass), and a reserved command goes straight
// to the result. The next request can be accepted in the same cycle as the result
// appears. The key and rank memories are scanned one entry per cycle.
// Reset is synchronous; it clears the valid bits and restores rank order with
// no clearing pass. A result held on rsp stalls only the next completion.
module assoc_lru_tag_store
  import alts_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  alts_req_if.sink   req,
  alts_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [IDX_W-1:0]    rd_addr;
  store_ctl_t          st_ctl;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [IDX_W-1:0]    wr_rank;
  logic [KEY_BITS-1:0] rd_key;
  logic [IDX_W-1:0]    rd_rank;
  logic                rd_valid;

  // Sequencer.
  alts_ctrl #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .rd_addr  (rd_addr),
    .st_ctl   (st_ctl),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_rank  (wr_rank),
    .rd_key   (rd_key),
    .rd_rank  (rd_rank),
    .rd_valid (rd_valid)
  );

  // Entry memories.
  alts_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .ctl      (st_ctl),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_rank  (wr_rank),
    .rd_key   (rd_key),
    .rd_rank  (rd_rank),
    .rd_valid (rd_valid)
  );

  // A request keeps the block busy in the cycle after it is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request channel ready right after an accepted request");

  // The store is written only while a request is in progress.
  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    st_ctl.wr_en |-> !req.ready)
    else $error("store written while idle");

  // A key fill always comes with a rank write.
  a_fill_with_rank: assert property (@(posedge clk) disable iff (rst)
    st_ctl.fill |-> st_ctl.wr_en)
    else $error("key fill without rank write");

  // A new result appears only at the end of a request in progress.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(!req.ready))
    else $error("result raised without a request in progress");

endmodule

// ===== dv/assoc_lru_tag_store_test.sv =====
// Self-checking testbench for the LRU tag store: directed and random requests against a shadow model.
`timescale 1ns / 1ps

module assoc_lru_tag_store_test;
  import alts_pkg::*;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 64;
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

  localparam int RANDOM_REQUESTS = 400;
  localparam int QUIET_TAIL      = 60;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int HOLD_OFF_AFTER  = 80;
  localparam int STALL_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int RECENT_DEPTH    = 32;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot_out;
    logic              replaced;
  } lookup_result_t;

  // Shadow copy of the tag store; predicts each result and checks what comes back.
  class lru_tag_shadow;
    bit               entry_valid [ENTRIES];
    logic [KEY_W-1:0] entry_key   [ENTRIES];
    int unsigned      entry_rank  [ENTRIES];
    lookup_result_t   awaited[$];
    int               mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] = 1'b0;
        entry_key[i]   = '0;
        entry_rank[i]  = i;
      end
      mismatches = 0;
    endfunction

    // Move one entry to the top of the recency order; ranks above it slide down.
    function void promote(int unsigned idx);
      int unsigned old_rank;
      old_rank = entry_rank[idx];
      for (int i = 0; i < ENTRIES; i++) begin
        if (entry_rank[i] > old_rank) entry_rank[i] = entry_rank[i] - 1;
      end
      entry_rank[idx] = ENTRIES - 1;
    endfunction

    // Apply one accepted request to the shadow state and queue its result.
    function void note_request(cmd_t op, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] slot);
      lookup_result_t   r;
      bit               hit;
      bit               have_free;
      int unsigned      pick;
      int unsigned      low_rank;
      logic [KEY_W-1:0] masked;
      r         = '0;
      hit       = 1'b0;
      have_free = 1'b0;
      pick      = 0;
      masked    = key & KEY_MASK;
      case (op)
        CMD_LOOKUP: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && entry_valid[i] && entry_key[i] == masked) begin
              hit        = 1'b1;
              r.found    = 1'b1;
              r.slot_out = SLOT_W'(i);
            end
          end
        end
        CMD_TOUCH: begin
          r.slot_out = slot;
          if (slot < ENTRIES) promote(slot);
        end
        CMD_INSERT: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!have_free && !entry_valid[i]) begin
              have_free = 1'b1;
              pick      = i;
            end
          end
          // With no free entry, evict the least recent one; ties go to the lower index.
          if (!have_free) begin
            low_rank = entry_rank[0];
            for (int i = 1; i < ENTRIES; i++) begin
              if (entry_rank[i] < low_rank) begin
                low_rank = entry_rank[i];
                pick     = i;
              end
            end
            r.replaced = 1'b1;
          end
          entry_key[pick]   = masked;
          entry_valid[pick] = 1'b1;
          promote(pick);
          r.slot_out = SLOT_W'(pick);
        end
        default: begin
          // The reserved command leaves the state alone and returns all zeros.
        end
      endcase
      awaited.push_back(r);
    endfunction

    // Compare one returned result with the oldest prediction, field by field.
    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result found=%0b slot_out=%0d replaced=%0b",
                 $time, got.found, got.slot_out, got.replaced);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
        mismatches++;
      end
      if (got.slot_out !== want.slot_out) begin
        $display("%0t: slot_out expected %0d actual %0d", $time, want.slot_out, got.slot_out);
        mismatches++;
      end
      if (got.replaced !== want.replaced) begin
        $display("%0t: replaced expected %0b actual %0b", $time, want.replaced, got.replaced);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  alts_req_if req ();
  alts_rsp_if rsp ();

  assoc_lru_tag_store #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  lru_tag_shadow    shadow;
  logic [KEY_W-1:0] recent_keys[$];
  bit               idle_on = 1'b1;
  int               accepted_requests = 0;

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels; predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        shadow.note_request(cmd_t'(req.cmd), req.key, req.slot);
        accepted_requests++;
      end
      if (rsp.valid && rsp.ready) begin
        shadow.check_result('{found: rsp.found, slot_out: rsp.slot_out, replaced: rsp.replaced});
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    bit held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && accepted_requests >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // End the run if nothing moves on either channel for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("assoc_lru_tag_store regression: fail");
    $finish;
  end

  // Offer one request, with an optional idle burst first, and wait until it is taken.
  task automatic send_request(cmd_t op, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] slot);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= op;
    req.key   <= key;
    req.slot  <= slot;
    do @(posedge clk); while (!req.ready);
    if (op == CMD_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
    end
  endtask

  initial begin
    shadow = new();
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.cmd   <= CMD_LOOKUP;
    req.key   <= '0;
    req.slot  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-store miss, key extremes, touch of an empty entry, reserved command,
    // duplicate insert, filling every entry and the first eviction.
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_INSERT, '0, '1);
    send_request(CMD_INSERT, '1, '0);
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_LOOKUP, '1, '1);
    send_request(CMD_TOUCH, '1, 4'd15);
    send_request(CMD_TOUCH, '0, 4'd0);
    send_request(CMD_RSVD, '1, '1);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 4'd10);
    send_request(CMD_INSERT, 64'h5555_5555_5555_5555, 4'd5);
    for (int i = 0; i < 11; i++) send_request(CMD_INSERT, {$urandom(), $urandom()}, '0);
    send_request(CMD_INSERT, 64'h8000_0000_0000_0001, '0);
    send_request(CMD_LOOKUP, '0, '0);

    // Random: mostly lookups of stored keys, inserts that keep evicting, and touches.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      int unsigned      roll;
      int unsigned      flip;
      cmd_t             op;
      logic [KEY_W-1:0] key;
      if (n == RANDOM_REQUESTS - QUIET_TAIL) idle_on = 1'b0;
      roll = $urandom_range(0, 99);
      key  = {$urandom(), $urandom()};
      if (roll < 35) op = CMD_LOOKUP;
      else if (roll < 70) op = CMD_INSERT;
      else if (roll < 95) op = CMD_TOUCH;
      else op = CMD_RSVD;
      if (op == CMD_LOOKUP && recent_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        // Now and then a single flipped bit, for a near miss.
        if ($urandom_range(0, 4) == 0) begin
          flip = $urandom_range(0, KEY_W - 1);
          key[flip] = ~key[flip];
        end
      end
      if (op == CMD_INSERT && recent_keys.size() > 0 && $urandom_range(0, 9) == 0) begin
        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end
      send_request(op, key, SLOT_W'($urandom_range(0, 15)));
    end
    req.valid <= 1'b0;

    // Drain outstanding results, then give the block time to show any stray one.
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("assoc_lru_tag_store regression: pass");
    end else begin
      $display("assoc_lru_tag_store regression: fail");
    end
    $finish;
  end

endmodule
